// ===== rtl/q15alu_pkg.sv =====
package q15alu_pkg;

   localparam int unsigned Q15W  = 16;
   localparam int unsigned ACCW  = 32;
   localparam int unsigned FLTW  = 32;

   localparam logic signed [Q15W-1:0] Q15_MAX = 16'sh7fff;
   localparam logic signed [Q15W-1:0] Q15_MIN = 16'sh8000;

   // half of a q15 lsb in q30
   localparam logic [32:0] HALF_LSB = 33'd16384;

   // float exponents that bound the in-range window
   localparam logic [7:0] EXP_ONE     = 8'd127;
   localparam logic [7:0] EXP_MIN_USE = 8'd110;
   localparam logic [7:0] EXP_SPECIAL = 8'd255;
   localparam logic [7:0] EXP_SHIFT   = 8'd135;
   localparam logic [7:0] EXP_Q2F     = 8'd112;

   typedef enum logic [2:0] {
      ACT_ADD = 3'd0,
      ACT_SUB = 3'd1,
      ACT_MUL = 3'd2,
      ACT_MAC = 3'd3,
      ACT_A2Q = 3'd4,
      ACT_F2Q = 3'd5,
      ACT_Q2F = 3'd6
   } action_type;

   typedef enum logic [1:0] {
      FCLS_ZERO = 2'd0,
      FCLS_SAT  = 2'd1,
      FCLS_NORM = 2'd2
   } fcls_type;

   // stage 1: operands decoded, product formed
   typedef struct packed {
      logic [2:0]          action;
      logic signed [31:0]  prod;
      logic signed [16:0]  sum;
      logic signed [16:0]  diff;
      logic signed [31:0]  acc;
      logic                fneg;
      fcls_type            fcls;
      logic [4:0]          fshift;
      logic [22:0]         fman;
      logic                aneg;
      logic [15:0]         amag;
   } s1_type;

   // stage 2: accumulate, rounding add, float alignment, leading one
   typedef struct packed {
      logic [2:0]          action;
      logic signed [16:0]  sum;
      logic signed [16:0]  diff;
      logic signed [31:0]  acc_new;
      logic                rneg;
      logic [17:0]         rq;
      logic                fneg;
      fcls_type            fcls;
      logic [14:0]         fq;
      logic                fguard;
      logic                fsticky;
      logic                aneg;
      logic [15:0]         amag;
      logic [3:0]          apos;
   } s2_type;

   // saturate a 17-bit sum to q15
   function automatic logic signed [15:0] sat17(input logic signed [16:0] v);
      logic signed [15:0] r;
      if (v[16] != v[15]) begin
         r = v[16] ? Q15_MIN : Q15_MAX;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/q15alu_if.sv =====
interface q15alu_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         action;
   logic signed [15:0] operand_a;
   logic signed [15:0] operand_b;
   logic signed [31:0] acc_in;
   logic [31:0]        float_in;

   modport source (output valid, action, operand_a, operand_b, acc_in, float_in,
                   input ready);
   modport sink   (input valid, action, operand_a, operand_b, acc_in, float_in,
                   output ready);
endinterface

interface q15alu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] q15_result;
   logic signed [31:0] acc_result;
   logic [31:0]        float_result;

   modport source (output valid, q15_result, acc_result, float_result,
                   input ready);
   modport sink   (input valid, q15_result, acc_result, float_result,
                   output ready);
endinterface

// ===== rtl/q15_dsp_arithmetic_unit_top.sv =====
// q15 saturating fixed-point alu. every item picks one action (saturating add or
// subtract, rounded q15 multiply, multiply-accumulate into a wrapping 32-bit q30
// accumulator, accumulator to q15, ieee single to q15, q15 to ieee single) and
// returns exactly one result item; fields that do not belong to the action are
// zero. the datapath is a three-stage pipeline: stage 1 forms the 16x16 product
// and decodes the operands, stage 2 does the accumulator add, the rounding add
// and the float alignment shift, stage 3 rounds, saturates and selects into the
// output register. an item accepted into the stage 1 register moves on through the
// stage 2 register into the output register, where its result is presented as valid;
// one item can enter every cycle while the result side does not stall. each stage
// holds its item while the stage after it is full and stalled, so a stall on the
// result side backs up at most three items before req_if.ready drops. the unit
// keeps no state between items.
module q15_dsp_arithmetic_unit_top (
   input  logic             clock,
   input  logic             reset,
   q15alu_req_if.sink       req_if,
   q15alu_rsp_if.source     rsp_if
);
   import q15alu_pkg::*;

   logic   v1_ff, v2_ff, v3_ff;
   logic   adv1, adv2, adv3;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;

   logic signed [15:0] q_ff, q_in;
   logic signed [31:0] accr_ff, accr_in;
   logic [31:0]        fout_ff, fout_in;

   // stall chain: a stage moves when it is empty or the next one moves
   assign adv3 = !v3_ff || rsp_if.ready;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_if.ready = adv1;

   // ---------------- stage 1 ----------------
   logic [7:0]  f_exp;
   logic [22:0] f_man;
   logic [7:0]  f_shift_w;

   always_comb begin
      f_exp     = req_if.float_in[30:23];
      f_man     = req_if.float_in[22:0];
      f_shift_w = EXP_SHIFT - f_exp;

      s1_in.action = req_if.action;
      s1_in.prod   = 32'(req_if.operand_a * req_if.operand_b);
      s1_in.sum    = 17'(req_if.operand_a) + 17'(req_if.operand_b);
      s1_in.diff   = 17'(req_if.operand_a) - 17'(req_if.operand_b);
      s1_in.acc    = req_if.acc_in;
      s1_in.fneg   = req_if.float_in[31];
      s1_in.fshift = f_shift_w[4:0];
      s1_in.fman   = f_man;

      // classify the float: nan, zero/subnormal and tiny values give 0
      if (f_exp == EXP_SPECIAL) begin
         s1_in.fcls = (f_man != '0) ? FCLS_ZERO : FCLS_SAT;
      end else if (f_exp == '0) begin
         s1_in.fcls = FCLS_ZERO;
      end else if (f_exp >= EXP_ONE) begin
         s1_in.fcls = FCLS_SAT;
      end else if (f_exp < EXP_MIN_USE) begin
         s1_in.fcls = FCLS_ZERO;
      end else begin
         s1_in.fcls = FCLS_NORM;
      end

      // magnitude of operand_a, -32768 maps to 0x8000
      s1_in.aneg = req_if.operand_a[15];
      s1_in.amag = req_if.operand_a[15] ? (~req_if.operand_a + 16'd1)
                                        : req_if.operand_a;
   end

   // ---------------- stage 2 ----------------
   logic signed [31:0] r_x;
   logic [31:0]        r_mag;
   logic [32:0]        r_sum;
   logic [48:0]        f_ext;

   always_comb begin
      s2_in.action  = s1_ff.action;
      s2_in.sum     = s1_ff.sum;
      s2_in.diff    = s1_ff.diff;
      s2_in.acc_new = s1_ff.acc + s1_ff.prod;

      // q30 rounding: half away from zero on the magnitude
      r_x   = (s1_ff.action == ACT_MUL) ? s1_ff.prod : s1_ff.acc;
      r_mag = r_x[31] ? (~r_x + 32'd1) : r_x;
      r_sum = {1'b0, r_mag} + HALF_LSB;
      s2_in.rneg = r_x[31];
      s2_in.rq   = r_sum[32:15];

      // align significand; shift is 9..25 for in-range values
      f_ext = {1'b1, s1_ff.fman, 25'd0} >> s1_ff.fshift;
      s2_in.fneg    = s1_ff.fneg;
      s2_in.fcls    = s1_ff.fcls;
      s2_in.fq      = f_ext[39:25];
      s2_in.fguard  = f_ext[24];
      s2_in.fsticky = |f_ext[23:0];

      s2_in.aneg = s1_ff.aneg;
      s2_in.amag = s1_ff.amag;
      // leading one of the magnitude
      s2_in.apos = '0;
      for (int i = 0; i < 16; i++) begin
         if (s1_ff.amag[i]) begin
            s2_in.apos = 4'(i);
         end
      end
   end

   // ---------------- stage 3 ----------------
   logic signed [15:0] rnd_q;
   logic [15:0]        f_q;
   logic signed [15:0] f2q;
   logic [23:0]        mant_w;
   logic [7:0]         exp_w;
   logic [31:0]        q2f;

   always_comb begin
      // saturate the rounded q30 value
      if (s2_ff.rneg) begin
         rnd_q = (s2_ff.rq > 18'd32768) ? Q15_MIN : -$signed(s2_ff.rq[15:0]);
      end else begin
         rnd_q = (s2_ff.rq > 18'd32767) ? Q15_MAX : $signed(s2_ff.rq[15:0]);
      end

      // round to nearest even, then sign and saturate
      f_q = {1'b0, s2_ff.fq} +
            16'(s2_ff.fguard && (s2_ff.fsticky || s2_ff.fq[0]));
      unique case (s2_ff.fcls)
         FCLS_SAT:  f2q = s2_ff.fneg ? Q15_MIN : Q15_MAX;
         FCLS_NORM: begin
            if (s2_ff.fneg) begin
               f2q = -$signed(f_q);
            end else begin
               f2q = (f_q > 16'd32767) ? Q15_MAX : $signed(f_q);
            end
         end
         default:   f2q = '0;
      endcase

      // exact q15 to single
      mant_w = {8'd0, s2_ff.amag} << (5'd23 - 5'(s2_ff.apos));
      exp_w  = EXP_Q2F + 8'(s2_ff.apos);
      if (s2_ff.amag == '0) begin
         q2f = '0;
      end else begin
         q2f = {s2_ff.aneg, exp_w, mant_w[22:0]};
      end

      q_in    = '0;
      accr_in = '0;
      fout_in = '0;
      unique case (s2_ff.action)
         ACT_ADD: q_in    = sat17(s2_ff.sum);
         ACT_SUB: q_in    = sat17(s2_ff.diff);
         ACT_MUL: q_in    = rnd_q;
         ACT_MAC: accr_in = s2_ff.acc_new;
         ACT_A2Q: q_in    = rnd_q;
         ACT_F2Q: q_in    = f2q;
         ACT_Q2F: fout_in = q2f;
         default: begin
            // unused action code gives an all-zero item
            q_in = '0;
         end
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= req_if.valid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_ff <= s1_in;
      end
      if (adv2) begin
         s2_ff <= s2_in;
      end
      if (adv3) begin
         q_ff    <= q_in;
         accr_ff <= accr_in;
         fout_ff <= fout_in;
      end
   end

   assign rsp_if.valid        = v3_ff;
   assign rsp_if.q15_result   = q_ff;
   assign rsp_if.acc_result   = accr_ff;
   assign rsp_if.float_result = fout_ff;

endmodule

// ===== rtl/q15alu_checker.sv =====
module q15alu_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] q15_result,
   input logic signed [31:0] acc_result,
   input logic [31:0]        float_result
);
   logic [2:0] pend_ff, pend_in;
   logic       req_take, rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // items accepted but not yet delivered
   always_comb begin
      pend_in = pend_ff + 3'(req_take) - 3'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      (pend_ff <= 3'd3) && (rsp_valid ? (pend_ff != 3'd0) : 1'b1))
      else $error("items in flight exceed pipeline depth or result without item");

   a_one_field: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (acc_result != 32'd0) |-> (q15_result == 16'sd0) &&
                                             (float_result == 32'd0))
      else $error("more than one result field set");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(q15_result) &&
                                  $stable(acc_result) && $stable(float_result))
      else $error("stalled result changed");

endmodule

bind q15_dsp_arithmetic_unit_top q15alu_checker u_q15alu_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .q15_result   (rsp_if.q15_result),
   .acc_result   (rsp_if.acc_result),
   .float_result (rsp_if.float_result)
);
